FILE: sv/slkp_pkg.sv
// Package for the short/long key press detector.
// Holds the event and queue entry types, register indexes and reset values.
// No dependencies.
package slkp_pkg;

   localparam int unsigned NUM_KEYS  = 2;
   localparam int unsigned TIME_W    = 64;
   localparam int unsigned THRESH_W  = 24;
   localparam int unsigned CODE_W    = 8;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 24;
   localparam int unsigned REQ_DATA_W = 72;
   localparam int unsigned RSP_DATA_W = 16;

   localparam int unsigned QUEUE_DEPTH_DEF = 2;

   // Register indexes on the csr port
   localparam logic [CSR_ADDR_W-1:0] CSR_SHORT_MIN  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LONG_MIN   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_K0_SHORT   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_K0_LONG    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_K1_SHORT   = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_K1_LONG    = 3'd5;

   // Reset values of the registers
   localparam logic [THRESH_W-1:0] SHORT_MIN_RST = 24'd50000;
   localparam logic [THRESH_W-1:0] LONG_MIN_RST  = 24'd800000;
   localparam logic [CODE_W-1:0]   K0_SHORT_RST  = 8'd4;
   localparam logic [CODE_W-1:0]   K0_LONG_RST   = 8'd2;
   localparam logic [CODE_W-1:0]   K1_SHORT_RST  = 8'd3;
   localparam logic [CODE_W-1:0]   K1_LONG_RST   = 8'd1;

   typedef struct packed {
      logic              key_index;
      logic [CODE_W-1:0] event_code;
      logic              is_long;
   } event_type;

   // One scan's worth of events, in emission order
   typedef struct packed {
      event_type ev0;
      event_type ev1;
      logic      two;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: sv/short_long_key_press_detector.sv
// Top level of the two-key short/long press detector.
// Instantiates slkp_front, slkp_queue and slkp_back; depends on slkp_pkg.
//
//   Channel  Direction  Beat contents
//   -------  ---------  ------------------------------------------------------
//   req_     in         tdata: now_time[63:0], key_levels[65:64], zero pad
//   rsp_     out        tdata: key_index[0], event_code[8:1], zero pad;
//                       tuser: is_long; tlast: final event of the scan
//   csr_     in         write enable, register index, 24-bit write data
//
// A scan is classified in the cycle it is accepted; each key gets one 64-bit
// subtract and compares against the 24-bit thresholds. Scans with events
// enter the queue, and the back end sends one event per cycle while rsp_tready
// is high, so the two events of a scan leave one after the other.
// The output register lets a new scan be taken while an event waits.
// Reset is synchronous: press state clears, registers take their defaults.
// A stall on rsp_ fills the queue, and req_tready drops only when it is full.
module short_long_key_press_detector #(
   parameter int unsigned QUEUE_DEPTH = slkp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Configuration writes
   input  logic                              csr_we,
   input  logic [slkp_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [slkp_pkg::CSR_DATA_W-1:0]   csr_wdata,
   // Scan input
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [slkp_pkg::REQ_DATA_W-1:0]   req_tdata,   // now_time, key_levels
   // Event output
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [slkp_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // key_index, event_code
   output logic                              rsp_tuser,   // is_long
   output logic                              rsp_tlast
);

   slkp_pkg::queue_status_type q_status;
   slkp_pkg::entry_type        push_entry;
   slkp_pkg::entry_type        head;
   slkp_pkg::event_type        rsp_event;
   logic                       push;
   logic                       pop;

   // Front: registers, key state, classify scan
   slkp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .scan_valid (req_tvalid),
      .scan_ready (req_tready),
      .now_time   (req_tdata[slkp_pkg::TIME_W-1:0]),
      .key_levels (req_tdata[slkp_pkg::TIME_W +: slkp_pkg::NUM_KEYS]),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   // Decouple: hold pending scan entries
   slkp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   // Back: serialize events onto the output
   slkp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_event  (rsp_event),
      .rsp_last   (rsp_tlast)
   );

   // Pack key_index low, event_code above it, zero the rest
   assign rsp_tdata = {{(slkp_pkg::RSP_DATA_W - slkp_pkg::CODE_W - 1){1'b0}},
                       rsp_event.event_code, rsp_event.key_index};
   assign rsp_tuser = rsp_event.is_long;

endmodule

FILE: sv/slkp_front.sv
// Front end of the key press detector: config registers, per-key press state,
// scan classification and packing of up to two events per scan.
// Depends on slkp_pkg.
module slkp_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [slkp_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [slkp_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                scan_valid,
   output logic                                scan_ready,
   input  logic [slkp_pkg::TIME_W-1:0]         now_time,
   input  logic [slkp_pkg::NUM_KEYS-1:0]       key_levels,
   input  slkp_pkg::queue_status_type          q_status,
   output logic                                push,
   output slkp_pkg::entry_type                 push_entry
);

   logic [slkp_pkg::THRESH_W-1:0] short_min_ff, short_min_in;
   logic [slkp_pkg::THRESH_W-1:0] long_min_ff, long_min_in;
   logic [slkp_pkg::CODE_W-1:0]   short_code_ff [slkp_pkg::NUM_KEYS];
   logic [slkp_pkg::CODE_W-1:0]   short_code_in [slkp_pkg::NUM_KEYS];
   logic [slkp_pkg::CODE_W-1:0]   long_code_ff  [slkp_pkg::NUM_KEYS];
   logic [slkp_pkg::CODE_W-1:0]   long_code_in  [slkp_pkg::NUM_KEYS];

   logic [slkp_pkg::NUM_KEYS-1:0] held_ff, held_in;
   logic [slkp_pkg::NUM_KEYS-1:0] long_done_ff, long_done_in;
   logic [slkp_pkg::TIME_W-1:0]   start_ff [slkp_pkg::NUM_KEYS];
   logic [slkp_pkg::TIME_W-1:0]   start_in [slkp_pkg::NUM_KEYS];

   logic                          accept;
   logic [slkp_pkg::NUM_KEYS-1:0] fire;
   slkp_pkg::event_type           ev [slkp_pkg::NUM_KEYS];

   assign scan_ready = !q_status.full;
   assign accept     = scan_valid && scan_ready;

   // Config writes; unknown indexes fall through
   always_comb begin
      short_min_in     = short_min_ff;
      long_min_in      = long_min_ff;
      short_code_in[0] = short_code_ff[0];
      long_code_in[0]  = long_code_ff[0];
      short_code_in[1] = short_code_ff[1];
      long_code_in[1]  = long_code_ff[1];
      if (csr_we) begin
         case (csr_addr)
            slkp_pkg::CSR_SHORT_MIN: short_min_in     = csr_wdata;
            slkp_pkg::CSR_LONG_MIN:  long_min_in      = csr_wdata;
            slkp_pkg::CSR_K0_SHORT:  short_code_in[0] = csr_wdata[slkp_pkg::CODE_W-1:0];
            slkp_pkg::CSR_K0_LONG:   long_code_in[0]  = csr_wdata[slkp_pkg::CODE_W-1:0];
            slkp_pkg::CSR_K1_SHORT:  short_code_in[1] = csr_wdata[slkp_pkg::CODE_W-1:0];
            slkp_pkg::CSR_K1_LONG:   long_code_in[1]  = csr_wdata[slkp_pkg::CODE_W-1:0];
            default: ;
         endcase
      end
   end

   // Keys are independent; each gets its own subtract and two compares
   always_comb begin
      logic [slkp_pkg::TIME_W-1:0] elapsed;
      logic                        down;
      logic                        hi_set;
      logic                        over_long;
      logic                        over_short;
      logic                        fire_long;
      logic                        fire_short;
      for (int i = 0; i < slkp_pkg::NUM_KEYS; i++) begin
         down       = !key_levels[i];
         elapsed    = now_time - start_ff[i];
         hi_set     = |elapsed[slkp_pkg::TIME_W-1:slkp_pkg::THRESH_W];
         over_long  = hi_set || (elapsed[slkp_pkg::THRESH_W-1:0] > long_min_ff);
         over_short = hi_set || (elapsed[slkp_pkg::THRESH_W-1:0] > short_min_ff);
         fire_long  = down && held_ff[i] && !long_done_ff[i] && over_long;
         fire_short = !down && held_ff[i] && !long_done_ff[i] && over_short;

         fire[i]          = fire_long || fire_short;
         ev[i].key_index  = 1'(i);
         ev[i].event_code = fire_long ? long_code_ff[i] : short_code_ff[i];
         ev[i].is_long    = fire_long;

         held_in[i]      = held_ff[i];
         long_done_in[i] = long_done_ff[i];
         start_in[i]     = start_ff[i];
         if (accept) begin
            if (down && !held_ff[i]) begin
               // new press: record only
               held_in[i]      = 1'b1;
               start_in[i]     = now_time;
               long_done_in[i] = 1'b0;
            end else if (fire_long) begin
               long_done_in[i] = 1'b1;
            end else if (!down) begin
               held_in[i] = 1'b0;
            end
         end
      end
   end

   // Compact the events so key 0 leads
   always_comb begin
      push = accept && (|fire);
      if (fire[0]) begin
         push_entry.ev0 = ev[0];
         push_entry.ev1 = ev[1];
         push_entry.two = fire[1];
      end else begin
         push_entry.ev0 = ev[1];
         push_entry.ev1 = ev[1];
         push_entry.two = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_min_ff     <= slkp_pkg::SHORT_MIN_RST;
         long_min_ff      <= slkp_pkg::LONG_MIN_RST;
         short_code_ff[0] <= slkp_pkg::K0_SHORT_RST;
         long_code_ff[0]  <= slkp_pkg::K0_LONG_RST;
         short_code_ff[1] <= slkp_pkg::K1_SHORT_RST;
         long_code_ff[1]  <= slkp_pkg::K1_LONG_RST;
         held_ff          <= '0;
         long_done_ff     <= '0;
      end else begin
         short_min_ff     <= short_min_in;
         long_min_ff      <= long_min_in;
         short_code_ff[0] <= short_code_in[0];
         long_code_ff[0]  <= long_code_in[0];
         short_code_ff[1] <= short_code_in[1];
         long_code_ff[1]  <= long_code_in[1];
         held_ff          <= held_in;
         long_done_ff     <= long_done_in;
      end
   end

   // Press timestamps are only read while the key is held
   always_ff @(posedge clock) begin
      for (int i = 0; i < slkp_pkg::NUM_KEYS; i++) begin
         start_ff[i] <= start_in[i];
      end
   end

endmodule

FILE: sv/slkp_queue.sv
// Small register queue of per-scan event entries between front and back.
// Depends on slkp_pkg.
module slkp_queue #(
   parameter int unsigned DEPTH = slkp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  slkp_pkg::entry_type        push_entry,
   input  logic                       pop,
   output slkp_pkg::entry_type        head,
   output slkp_pkg::queue_status_type status
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   slkp_pkg::entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: sv/slkp_back.sv
// Back end of the key press detector: walks the head entry one event per
// beat into the output register and marks the scan's final event.
// Depends on slkp_pkg.
module slkp_back (
   input  logic                              clock,
   input  logic                              reset,
   input  slkp_pkg::entry_type               head,
   input  slkp_pkg::queue_status_type        q_status,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output slkp_pkg::event_type               rsp_event,
   output logic                              rsp_last
);

   logic                valid_ff, valid_in;
   logic                sel_ff, sel_in;
   slkp_pkg::event_type ev_ff, ev_in;
   logic                last_ff, last_in;
   logic                load;
   logic                head_last;

   // Load when the output register is empty or being drained this cycle
   assign load      = !q_status.empty && (!valid_ff || rsp_tready);
   assign head_last = sel_ff || !head.two;
   assign pop       = load && head_last;

   always_comb begin
      valid_in = valid_ff;
      sel_in   = sel_ff;
      ev_in    = ev_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         ev_in    = sel_ff ? head.ev1 : head.ev0;
         last_in  = head_last;
         sel_in   = !head_last;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_ff   <= ev_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_event  = ev_ff;
   assign rsp_last   = last_ff;

endmodule
